/* rtl/qrr_pkg.sv */
// Package for the quantized ReLU requantizer: register map, config bundle,
// datapath widths and saturation bounds. No dependencies.
package qrr_pkg;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = 17;
  localparam int MULT_W   = 31;
  localparam int PROD_W   = 48;
  localparam int RND_W    = 49;
  localparam int ACC_W    = 32;
  localparam int SHIFT_W  = 6;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_IN_ZP    = 3'd0;
  localparam reg_idx_t REG_OUT_ZP   = 3'd1;
  localparam reg_idx_t REG_MULT     = 3'd2;
  localparam reg_idx_t REG_SHIFT    = 3'd3;
  localparam reg_idx_t REG_CLAMP_LO = 3'd4;
  localparam reg_idx_t REG_CLAMP_HI = 3'd5;
  localparam reg_idx_t REG_WIDE     = 3'd6;

  // Reset values
  localparam logic [SAMPLE_W-1:0] IN_ZP_RST    = 16'h0000;
  localparam logic [SAMPLE_W-1:0] OUT_ZP_RST   = 16'h0000;
  localparam logic [MULT_W-1:0]   MULT_RST     = 31'h4000_0000;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST    = 6'd0;
  localparam logic [SAMPLE_W-1:0] CLAMP_LO_RST = 16'hFF80;
  localparam logic [SAMPLE_W-1:0] CLAMP_HI_RST = 16'h007F;

  // int8 saturation bounds, sign-extended to 16 bits
  localparam logic [SAMPLE_W-1:0] NARROW_MIN = 16'hFF80;
  localparam logic [SAMPLE_W-1:0] NARROW_MAX = 16'h007F;

  // Shift setting at which rounding stops (effective shift would be 0)
  localparam logic [SHIFT_W-2:0] SHIFT_NO_RND = 5'd31;
  localparam logic [SHIFT_W-2:0] SHIFT_BASE   = 5'd31;

  typedef struct packed {
    logic [SAMPLE_W-1:0] in_zp;
    logic [SAMPLE_W-1:0] out_zp;
    logic [MULT_W-1:0]   mult;
    logic [SHIFT_W-1:0]  shift;
    logic [SAMPLE_W-1:0] clamp_lo;
    logic [SAMPLE_W-1:0] clamp_hi;
    logic                wide;
  } cfg_t;

endpackage

/* rtl/qrr_cfg.sv */
// Configuration register file with APB-style access for the requantizer.
// Depends on qrr_pkg (register map, cfg_t, reset values).
module qrr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qrr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qrr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qrr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output qrr_pkg::cfg_t                  cfg
);

  qrr_pkg::cfg_t    cfg_r;
  qrr_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[qrr_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_zp    <= qrr_pkg::IN_ZP_RST;
      cfg_r.out_zp   <= qrr_pkg::OUT_ZP_RST;
      cfg_r.mult     <= qrr_pkg::MULT_RST;
      cfg_r.shift    <= qrr_pkg::SHIFT_RST;
      cfg_r.clamp_lo <= qrr_pkg::CLAMP_LO_RST;
      cfg_r.clamp_hi <= qrr_pkg::CLAMP_HI_RST;
      cfg_r.wide     <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        qrr_pkg::REG_IN_ZP:    cfg_r.in_zp    <= pwdata[15:0];
        qrr_pkg::REG_OUT_ZP:   cfg_r.out_zp   <= pwdata[15:0];
        qrr_pkg::REG_MULT:     cfg_r.mult     <= pwdata[30:0];
        qrr_pkg::REG_SHIFT:    cfg_r.shift    <= pwdata[5:0];
        qrr_pkg::REG_CLAMP_LO: cfg_r.clamp_lo <= pwdata[15:0];
        qrr_pkg::REG_CLAMP_HI: cfg_r.clamp_hi <= pwdata[15:0];
        qrr_pkg::REG_WIDE:     cfg_r.wide     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux, raw register bits zero-extended
  always_comb begin
    case (reg_idx)
      qrr_pkg::REG_IN_ZP:    prdata = {16'h0000, cfg_r.in_zp};
      qrr_pkg::REG_OUT_ZP:   prdata = {16'h0000, cfg_r.out_zp};
      qrr_pkg::REG_MULT:     prdata = {1'b0, cfg_r.mult};
      qrr_pkg::REG_SHIFT:    prdata = {26'h0, cfg_r.shift};
      qrr_pkg::REG_CLAMP_LO: prdata = {16'h0000, cfg_r.clamp_lo};
      qrr_pkg::REG_CLAMP_HI: prdata = {16'h0000, cfg_r.clamp_hi};
      qrr_pkg::REG_WIDE:     prdata = {31'h0, cfg_r.wide};
      default:               prdata = '0;
    endcase
  end

endmodule

/* rtl/qrr_mul.sv */
// Stages 1-2: input zero point subtract, then signed Q31 multiply.
// Depends on qrr_pkg (cfg_t, widths).
module qrr_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qrr_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [qrr_pkg::SAMPLE_W-1:0] in_data,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qrr_pkg::PROD_W-1:0]   out_prod,
  output logic                         out_last,
  output logic [1:0]                   stage_valid
);

  logic                        s1_v_r, s1_last_r, s1_rdy;
  logic [qrr_pkg::DIFF_W-1:0]  s1_diff_r, s1_diff_nxt;
  logic                        s2_v_r, s2_last_r, s2_rdy;
  logic [qrr_pkg::PROD_W-1:0]  s2_prod_r, s2_prod_nxt;
  logic [qrr_pkg::SAMPLE_W-1:0] x16;
  logic signed [qrr_pkg::RND_W-1:0] prod_full;

  assign s2_rdy      = !s2_v_r || out_ready;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ready    = s1_rdy;
  assign out_valid   = s2_v_r;
  assign out_prod    = s2_prod_r;
  assign out_last    = s2_last_r;
  assign stage_valid = {s2_v_r, s1_v_r};

  // Element select by mode and zero point subtract (17-bit, no overflow)
  always_comb begin
    x16 = cfg.wide ? in_data : {{8{in_data[7]}}, in_data[7:0]};
    s1_diff_nxt = {x16[15], x16} - {cfg.in_zp[15], cfg.in_zp};
  end

  // 17 x 32 signed product; magnitude stays below 2^47
  always_comb begin
    prod_full   = $signed(s1_diff_r) * $signed({1'b0, cfg.mult});
    s2_prod_nxt = prod_full[qrr_pkg::PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  // Payload registers load only when their stage takes an item
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_diff_r <= s1_diff_nxt;
      s1_last_r <= in_last;
    end
    if (s2_rdy && s1_v_r) begin
      s2_prod_r <= s2_prod_nxt;
      s2_last_r <= s1_last_r;
    end
  end

endmodule

/* rtl/qrr_round.sv */
// Stages 3-4: rounding right shift of the product, then output zero point add.
// Depends on qrr_pkg (cfg_t, widths, shift constants).
module qrr_round (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qrr_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qrr_pkg::PROD_W-1:0] in_prod,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qrr_pkg::ACC_W-1:0]  out_acc,
  output logic                       out_last,
  output logic [1:0]                 stage_valid
);

  logic                       s3_v_r, s3_last_r, s3_rdy;
  logic [qrr_pkg::ACC_W-1:0]  s3_acc_r, s3_acc_nxt;
  logic                       s4_v_r, s4_last_r, s4_rdy;
  logic [qrr_pkg::ACC_W-1:0]  s4_acc_r, s4_acc_nxt;
  logic                       rnd_en;
  logic [4:0]                 eff_shift, half_pos;
  logic [qrr_pkg::RND_W-1:0]  rnd_bit, rnd_sum;
  logic signed [qrr_pkg::RND_W-1:0] rnd_shifted;

  assign s4_rdy      = !s4_v_r || out_ready;
  assign s3_rdy      = !s3_v_r || s4_rdy;
  assign in_ready    = s3_rdy;
  assign out_valid   = s4_v_r;
  assign out_acc     = s4_acc_r;
  assign out_last    = s4_last_r;
  assign stage_valid = {s4_v_r, s3_v_r};

  // Rounding applies when the effective shift 31 - shift lies in 1..31
  always_comb begin
    rnd_en      = !cfg.shift[5] && (cfg.shift[4:0] != qrr_pkg::SHIFT_NO_RND);
    eff_shift   = qrr_pkg::SHIFT_BASE - cfg.shift[4:0];
    half_pos    = eff_shift - 5'd1;
    rnd_bit     = qrr_pkg::RND_W'(1) << half_pos;
    rnd_sum     = {in_prod[qrr_pkg::PROD_W-1], in_prod} + rnd_bit;
    rnd_shifted = $signed(rnd_sum) >>> eff_shift;
    s3_acc_nxt  = rnd_en ? rnd_shifted[qrr_pkg::ACC_W-1:0] : in_prod[qrr_pkg::ACC_W-1:0];
  end

  // Output zero point, 32-bit wrap
  assign s4_acc_nxt = s3_acc_r + {{16{cfg.out_zp[15]}}, cfg.out_zp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_r <= in_valid;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && in_valid) begin
      s3_acc_r  <= s3_acc_nxt;
      s3_last_r <= in_last;
    end
    if (s4_rdy && s3_v_r) begin
      s4_acc_r  <= s4_acc_nxt;
      s4_last_r <= s3_last_r;
    end
  end

endmodule

/* rtl/qrr_clamp.sv */
// Stage 5: activation clamp and int8/int16 saturation into the output register.
// Depends on qrr_pkg (cfg_t, widths, saturation bounds).
module qrr_clamp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qrr_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [qrr_pkg::ACC_W-1:0]    in_acc,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qrr_pkg::SAMPLE_W-1:0] out_data,
  output logic                         out_last
);

  logic                         s5_v_r, s5_last_r, s5_rdy;
  logic [qrr_pkg::SAMPLE_W-1:0] s5_data_r, s5_data_nxt;
  logic signed [qrr_pkg::ACC_W-1:0] v32, lo32, hi32;
  logic signed [qrr_pkg::SAMPLE_W-1:0] c16;

  assign s5_rdy    = !s5_v_r || out_ready;
  assign in_ready  = s5_rdy;
  assign out_valid = s5_v_r;
  assign out_data  = s5_data_r;
  assign out_last  = s5_last_r;

  // Max with low bound first, then min with high bound; result fits 16 bits
  always_comb begin
    lo32 = $signed({{16{cfg.clamp_lo[15]}}, cfg.clamp_lo});
    hi32 = $signed({{16{cfg.clamp_hi[15]}}, cfg.clamp_hi});
    v32  = $signed(in_acc);
    if (v32 < lo32) v32 = lo32;
    if (v32 > hi32) v32 = hi32;
    c16 = v32[qrr_pkg::SAMPLE_W-1:0];
    s5_data_nxt = c16;
    if (!cfg.wide) begin
      if (c16 < $signed(qrr_pkg::NARROW_MIN)) s5_data_nxt = qrr_pkg::NARROW_MIN;
      if (c16 > $signed(qrr_pkg::NARROW_MAX)) s5_data_nxt = qrr_pkg::NARROW_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && in_valid) begin
      s5_data_r <= s5_data_nxt;
      s5_last_r <= in_last;
    end
  end

endmodule

/* rtl/quantized_relu_requantizer.sv */
// Top level of the quantized ReLU requantizer: five-stage element pipeline.
// Depends on qrr_pkg, qrr_cfg, qrr_mul, qrr_round, qrr_clamp.
//
//   channel | direction | handshake          | payload
//   in_     | slave     | tvalid/tready      | tdata[15:0] sample_in, tlast last_in
//   out_    | master    | tvalid/tready      | tdata[15:0] sample_out, tlast last_out
//   cfg_    | APB slave | psel/penable/pready| 7 registers at 4*index
//
// One item per cycle sustained while out_tready stays high; an accepted item passes
// through the five registered stages in order (subtract, multiply, round-shift,
// zero point add, clamp) before out_tvalid rises.
// Reset (rst_n low, synchronous) empties all stages and loads register defaults.
// Each stage holds its item while the next one is full and stalled, so bubbles
// close up; in_tready drops only when all five stages are full and out_tready is low.
module quantized_relu_requantizer (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // [15:0] sample_in
  input  logic                           in_tlast,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // [15:0] sample_out
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [qrr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [qrr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [qrr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  qrr_pkg::cfg_t              cfg;
  logic                       mul_valid, mul_ready, mul_last;
  logic [qrr_pkg::PROD_W-1:0] mul_prod;
  logic                       rnd_valid, rnd_ready, rnd_last;
  logic [qrr_pkg::ACC_W-1:0]  rnd_acc;
  logic [1:0]                 mul_stage_v, rnd_stage_v;

  // Register file
  qrr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Subtract and multiply
  qrr_mul u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data     (in_tdata),
    .in_last     (in_tlast),
    .out_valid   (mul_valid),
    .out_ready   (mul_ready),
    .out_prod    (mul_prod),
    .out_last    (mul_last),
    .stage_valid (mul_stage_v)
  );

  // Rounding shift and output zero point
  qrr_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (mul_valid),
    .in_ready    (mul_ready),
    .in_prod     (mul_prod),
    .in_last     (mul_last),
    .out_valid   (rnd_valid),
    .out_ready   (rnd_ready),
    .out_acc     (rnd_acc),
    .out_last    (rnd_last),
    .stage_valid (rnd_stage_v)
  );

  // Clamp, saturate, output register
  qrr_clamp u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (rnd_valid),
    .in_ready  (rnd_ready),
    .in_acc    (rnd_acc),
    .in_last   (rnd_last),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  // Input backpressure only when every stage is occupied and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (mul_stage_v == 2'b11 && rnd_stage_v == 2'b11 &&
                    out_tvalid && !out_tready))
    else $error("input stalled with a bubble in the pipeline");

  // Narrow mode results are int8 sign-extended
  a_narrow_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !cfg.wide) |-> (out_tdata[15:8] == {8{out_tdata[7]}}))
    else $error("narrow result outside int8");

  // Wide mode with ordered bounds keeps results inside the clamp range
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cfg.wide && ($signed(cfg.clamp_lo) <= $signed(cfg.clamp_hi)))
    |-> ($signed(out_tdata) >= $signed(cfg.clamp_lo) &&
         $signed(out_tdata) <= $signed(cfg.clamp_hi)))
    else $error("result outside clamp range");

endmodule
